### rtl/tcpqd_pkg.sv
// Package for the three-class priority queue dispatcher.
// Holds field widths, status and command codes, and the structs passed between modules.
// No dependencies.
package tcpqd_pkg;

    localparam int NUM_CLASSES = 3;
    localparam int TAG_W       = 16;
    localparam int TIME_W      = 8;
    localparam int CLS_W       = 2;
    localparam int SRV_W       = 2;
    localparam int STAT_W      = 3;
    localparam int OCC_W       = 5;
    localparam int ENTRY_W     = TAG_W + TIME_W;

    localparam logic       MODE_ARRIVE = 1'b0;
    localparam logic       MODE_SERVE  = 1'b1;

    localparam logic [CLS_W-1:0] CLS_PAUSE = 2'd0;
    localparam logic [CLS_W-1:0] CLS_HIGH  = 2'd1;
    localparam logic [CLS_W-1:0] CLS_MID   = 2'd2;
    localparam logic [CLS_W-1:0] CLS_LOW   = 2'd3;

    typedef enum logic [STAT_W-1:0] {
        ARR_QUEUED  = 3'd0,
        ARR_DROPPED = 3'd1,
        ARR_PAUSE   = 3'd2,
        ARR_CLOSED  = 3'd3,
        ARR_NONE    = 3'd4
    } t_arr_status;

    typedef enum logic [1:0] {
        CMD_PAUSE = 2'd0,
        CMD_ITEM  = 2'd1,
        CMD_SERVE = 2'd2
    } t_cmd_kind;

    typedef enum logic {
        BK_EXEC = 1'b0,
        BK_READ = 1'b1
    } t_bk_state;

    typedef struct packed {
        t_cmd_kind                kind;
        logic [NUM_CLASSES-1:0]   cls_oh;
        logic [SRV_W-1:0]         srv;
        logic [TAG_W-1:0]         tag;
        logic [TIME_W-1:0]        svc_time;
    } t_cmd;

    typedef struct packed {
        t_arr_status              stat;
        logic                     grant;
        logic [CLS_W-1:0]         cls;
        logic [TAG_W-1:0]         tag;
        logic [TIME_W-1:0]        svc_time;
        logic [OCC_W-1:0]         occ;
        logic                     closed;
    } t_result;

endpackage

### rtl/tcpqd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcpqd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 20,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/tcpqd_front.sv
// Front end: accepts input items, classifies them into commands and queues them.
// Depends on tcpqd_pkg.
module tcpqd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_mode,
    input  logic [tcpqd_pkg::CLS_W-1:0]   i_arrival_class,
    input  logic [tcpqd_pkg::TAG_W-1:0]   i_customer_tag,
    input  logic [tcpqd_pkg::TIME_W-1:0]  i_service_time,
    input  logic [tcpqd_pkg::SRV_W-1:0]   i_server_index,
    output logic                          o_cmd_valid,
    output tcpqd_pkg::t_cmd               o_cmd,
    input  logic                          i_cmd_take
);

    tcpqd_pkg::t_cmd r_q [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_cnt;
    logic            n_wr_ptr;
    logic            n_rd_ptr;
    logic [1:0]      n_cnt;
    tcpqd_pkg::t_cmd cmd_in;
    logic            push;
    logic            pop;

    always_comb begin
        cmd_in          = '0;
        cmd_in.tag      = i_customer_tag;
        cmd_in.svc_time = i_service_time;
        cmd_in.srv      = i_server_index;
        if (i_mode == tcpqd_pkg::MODE_SERVE) begin
            cmd_in.kind = tcpqd_pkg::CMD_SERVE;
        end else if (i_arrival_class == tcpqd_pkg::CLS_PAUSE) begin
            cmd_in.kind = tcpqd_pkg::CMD_PAUSE;
        end else begin
            cmd_in.kind = tcpqd_pkg::CMD_ITEM;
        end
        case (i_arrival_class)
            tcpqd_pkg::CLS_HIGH: cmd_in.cls_oh = 3'b001;
            tcpqd_pkg::CLS_MID:  cmd_in.cls_oh = 3'b010;
            tcpqd_pkg::CLS_LOW:  cmd_in.cls_oh = 3'b100;
            default:             cmd_in.cls_oh = 3'b000;
        endcase
    end

    assign o_in_stall  = (r_cnt == 2'd2);
    assign push        = i_in_valid && !o_in_stall;
    assign pop         = i_cmd_take && o_cmd_valid;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ push;
        n_rd_ptr = r_rd_ptr ^ pop;
        n_cnt    = r_cnt;
        case ({push, pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

### rtl/tcpqd_back.sv
// Back end: carries out queued commands on the three class queues and registers results.
// Depends on tcpqd_pkg and tcpqd_ram.
module tcpqd_back #(
    parameter int TOTAL_SLOTS = 20,
    parameter int PAUSE_LIMIT = 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_policy,
    input  logic                i_cmd_valid,
    input  tcpqd_pkg::t_cmd     i_cmd,
    output logic                o_cmd_take,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tcpqd_pkg::t_result  o_result
);

    localparam int NQ      = tcpqd_pkg::NUM_CLASSES;
    localparam int CNT_W   = $clog2(TOTAL_SLOTS + 1);
    localparam int PTR_W   = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
    localparam int TOT_W   = (CNT_W + 2 > tcpqd_pkg::OCC_W) ? CNT_W + 2 : tcpqd_pkg::OCC_W;
    localparam int PAUSE_W = $clog2(PAUSE_LIMIT + 1);
    localparam int EW      = tcpqd_pkg::ENTRY_W;

    tcpqd_pkg::t_bk_state r_state, n_state;
    logic [PTR_W-1:0]     r_head [NQ];
    logic [PTR_W-1:0]     n_head [NQ];
    logic [CNT_W-1:0]     r_cnt  [NQ];
    logic [CNT_W-1:0]     n_cnt  [NQ];
    logic [PAUSE_W-1:0]   r_pause, n_pause;
    logic                 r_closed, n_closed;
    logic                 r_out_valid, n_out_valid;
    tcpqd_pkg::t_result   r_out, n_out;
    tcpqd_pkg::t_result   r_pend, n_pend;
    logic [NQ-1:0]        r_pend_sel, n_pend_sel;

    logic [PTR_W-1:0]     tail     [NQ];
    logic [PTR_W-1:0]     head_inc [NQ];
    logic [EW-1:0]        rd_data  [NQ];
    logic [NQ-1:0]        wr_en;
    logic [NQ-1:0]        rd_en;
    logic [NQ-1:0]        nonempty;
    logic [NQ-1:0]        sel_oh;
    logic [TOT_W-1:0]     total;
    logic [TOT_W-1:0]     n_total;
    logic                 full;
    logic                 out_free;
    logic                 pref_hit;
    logic [PAUSE_W:0]     pause_inc;

    always_comb begin
        logic [PTR_W:0] sum;
        for (int q = 0; q < NQ; q++) begin
            sum = {1'b0, r_head[q]} + (PTR_W + 1)'(r_cnt[q]);
            if (sum >= (PTR_W + 1)'(TOTAL_SLOTS)) begin
                sum = sum - (PTR_W + 1)'(TOTAL_SLOTS);
            end
            tail[q]     = sum[PTR_W-1:0];
            head_inc[q] = (r_head[q] == PTR_W'(TOTAL_SLOTS - 1)) ? '0 : r_head[q] + 1'b1;
            nonempty[q] = (r_cnt[q] != '0);
        end
    end

    always_comb begin
        pref_hit = 1'b0;
        sel_oh   = '0;
        for (int q = 0; q < NQ; q++) begin
            if (i_policy && (i_cmd.srv == tcpqd_pkg::SRV_W'(q)) && nonempty[q]) begin
                pref_hit  = 1'b1;
                sel_oh[q] = 1'b1;
            end
        end
        if (!pref_hit) begin
            if (nonempty[0]) begin
                sel_oh = 3'b001;
            end else if (nonempty[1]) begin
                sel_oh = 3'b010;
            end else if (nonempty[2]) begin
                sel_oh = 3'b100;
            end
        end
    end

    assign total     = TOT_W'(r_cnt[0]) + TOT_W'(r_cnt[1]) + TOT_W'(r_cnt[2]);
    assign n_total   = TOT_W'(n_cnt[0]) + TOT_W'(n_cnt[1]) + TOT_W'(n_cnt[2]);
    assign full      = (total >= TOT_W'(TOTAL_SLOTS));
    assign out_free  = !r_out_valid || !i_out_stall;
    assign pause_inc = {1'b0, r_pause} + 1'b1;

    always_comb begin
        tcpqd_pkg::t_arr_status stat;
        logic [NQ-1:0]          pop_oh;
        n_state     = r_state;
        n_head      = r_head;
        n_cnt       = r_cnt;
        n_pause     = r_pause;
        n_closed    = r_closed;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        n_pend      = r_pend;
        n_pend_sel  = r_pend_sel;
        wr_en       = '0;
        rd_en       = '0;
        o_cmd_take  = 1'b0;
        stat        = tcpqd_pkg::ARR_NONE;
        pop_oh      = '0;
        case (r_state)
            tcpqd_pkg::BK_EXEC: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_take = 1'b1;
                    case (i_cmd.kind)
                        tcpqd_pkg::CMD_PAUSE: begin
                            if (r_closed) begin
                                stat = tcpqd_pkg::ARR_CLOSED;
                            end else if (full) begin
                                stat = tcpqd_pkg::ARR_DROPPED;
                            end else begin
                                n_pause = pause_inc[PAUSE_W-1:0];
                                if (pause_inc >= (PAUSE_W + 1)'(PAUSE_LIMIT)) begin
                                    n_closed = 1'b1;
                                    stat     = tcpqd_pkg::ARR_CLOSED;
                                end else begin
                                    stat = tcpqd_pkg::ARR_PAUSE;
                                end
                            end
                        end
                        tcpqd_pkg::CMD_ITEM: begin
                            if (r_closed) begin
                                stat = tcpqd_pkg::ARR_CLOSED;
                            end else if (full) begin
                                stat = tcpqd_pkg::ARR_DROPPED;
                            end else begin
                                wr_en   = i_cmd.cls_oh;
                                n_pause = '0;
                                stat    = tcpqd_pkg::ARR_QUEUED;
                                for (int q = 0; q < NQ; q++) begin
                                    if (i_cmd.cls_oh[q]) begin
                                        n_cnt[q] = r_cnt[q] + CNT_W'(1);
                                    end
                                end
                            end
                        end
                        tcpqd_pkg::CMD_SERVE: begin
                            pop_oh = sel_oh;
                            rd_en  = sel_oh;
                            for (int q = 0; q < NQ; q++) begin
                                if (sel_oh[q]) begin
                                    n_cnt[q]  = r_cnt[q] - CNT_W'(1);
                                    n_head[q] = head_inc[q];
                                end
                            end
                        end
                        default: stat = tcpqd_pkg::ARR_NONE;
                    endcase
                    n_out.stat     = stat;
                    n_out.grant    = 1'b0;
                    n_out.cls      = '0;
                    n_out.tag      = '0;
                    n_out.svc_time = '0;
                    n_out.occ      = n_total[tcpqd_pkg::OCC_W-1:0];
                    n_out.closed   = n_closed;
                    if (pop_oh != '0) begin
                        n_pend       = n_out;
                        n_pend.grant = 1'b1;
                        for (int q = 0; q < NQ; q++) begin
                            if (pop_oh[q]) begin
                                n_pend.cls = tcpqd_pkg::CLS_W'(q + 1);
                            end
                        end
                        n_pend_sel = pop_oh;
                        n_out      = r_out;
                        n_state    = tcpqd_pkg::BK_READ;
                    end else begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            tcpqd_pkg::BK_READ: begin
                if (out_free) begin
                    n_out = r_pend;
                    for (int q = 0; q < NQ; q++) begin
                        if (r_pend_sel[q]) begin
                            n_out.tag      = rd_data[q][EW-1:tcpqd_pkg::TIME_W];
                            n_out.svc_time = rd_data[q][tcpqd_pkg::TIME_W-1:0];
                        end
                    end
                    n_out_valid = 1'b1;
                    n_state     = tcpqd_pkg::BK_EXEC;
                end
            end
            default: n_state = tcpqd_pkg::BK_EXEC;
        endcase
    end

    for (genvar g = 0; g < NQ; g++) begin : g_class_ram
        tcpqd_ram #(
            .WIDTH (EW),
            .DEPTH (TOTAL_SLOTS)
        ) u_ram (
            .i_clk     (i_clk),
            .i_wr_en   (wr_en[g]),
            .i_wr_addr (tail[g]),
            .i_wr_data ({i_cmd.tag, i_cmd.svc_time}),
            .i_rd_en   (rd_en[g]),
            .i_rd_addr (r_head[g]),
            .o_rd_data (rd_data[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcpqd_pkg::BK_EXEC;
            r_pause     <= '0;
            r_closed    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int q = 0; q < NQ; q++) begin
                r_head[q] <= '0;
                r_cnt[q]  <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_pause     <= n_pause;
            r_closed    <= n_closed;
            r_out_valid <= n_out_valid;
            r_head      <= n_head;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out      <= n_out;
        r_pend     <= n_pend;
        r_pend_sel <= n_pend_sel;
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

### rtl/three_class_priority_queue_dispatch.sv
// Top level of the three-class priority queue dispatcher: policy register, front end, back end.
// Depends on tcpqd_pkg, tcpqd_front, tcpqd_back (and tcpqd_ram through it).
//
//  Channel  | Direction | Handshake                 | Payload
//  ---------+-----------+---------------------------+--------------------------------------
//  in       | in        | i_in_valid / o_in_stall   | mode, class, tag, service time, server
//  out      | out       | o_out_valid / i_out_stall | status, grant, class, tag, time, occ.
//  cfg      | in        | i_cfg_valid / o_cfg_ready | preferred server policy bit
//
// The front end takes one item per cycle into a two-entry command queue while it is not full.
// The back end retires an arrival or an empty request from its execute state; a request that pops an
// entry also passes through a read state, for the registered read of the class RAM.
// Reset is synchronous, active low; queues come out of reset empty with no clearing pass.
// An output stall holds the result register; the back end then waits and the queue fills.
module three_class_priority_queue_dispatch #(
    parameter int TOTAL_SLOTS = 20,
    parameter int PAUSE_LIMIT = 3
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_mode,
    input  logic [tcpqd_pkg::CLS_W-1:0]         i_arrival_class,
    input  logic [tcpqd_pkg::TAG_W-1:0]         i_customer_tag,
    input  logic [tcpqd_pkg::TIME_W-1:0]        i_service_time,
    input  logic [tcpqd_pkg::SRV_W-1:0]         i_server_index,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [tcpqd_pkg::STAT_W-1:0]        o_arrival_status,
    output logic                                o_grant_valid,
    output logic [tcpqd_pkg::CLS_W-1:0]         o_granted_class,
    output logic [tcpqd_pkg::TAG_W-1:0]         o_granted_tag,
    output logic [tcpqd_pkg::TIME_W-1:0]        o_granted_time,
    output logic [tcpqd_pkg::OCC_W-1:0]         o_occupancy,
    output logic                                o_closed_flag
);

    logic               r_policy;
    logic               cmd_valid;
    logic               cmd_take;
    tcpqd_pkg::t_cmd    cmd;
    tcpqd_pkg::t_result result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= 1'b0;
        end else if (i_cfg_valid) begin
            r_policy <= i_cfg_data;
        end
    end

    tcpqd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_arrival_class (i_arrival_class),
        .i_customer_tag  (i_customer_tag),
        .i_service_time  (i_service_time),
        .i_server_index  (i_server_index),
        .o_cmd_valid     (cmd_valid),
        .o_cmd           (cmd),
        .i_cmd_take      (cmd_take)
    );

    tcpqd_back #(
        .TOTAL_SLOTS (TOTAL_SLOTS),
        .PAUSE_LIMIT (PAUSE_LIMIT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_policy    (r_policy),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (result)
    );

    assign o_arrival_status = result.stat;
    assign o_grant_valid    = result.grant;
    assign o_granted_class  = result.cls;
    assign o_granted_tag    = result.tag;
    assign o_granted_time   = result.svc_time;
    assign o_occupancy      = result.occ;
    assign o_closed_flag    = result.closed;

`ifndef SYNTHESIS
    a_take_needs_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_take |-> cmd_valid)
        else $error("back end took a command from an empty queue");

    a_no_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_grant_valid) |->
            (o_granted_class == '0 && o_granted_tag == '0 && o_granted_time == '0))
        else $error("grant fields set without a grant");

    a_grant_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_grant_valid) |->
            (o_arrival_status == tcpqd_pkg::ARR_NONE && o_granted_class != '0))
        else $error("granted result with arrival status or no class");

    a_queued_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_arrival_status == tcpqd_pkg::ARR_QUEUED) |-> !o_closed_flag)
        else $error("item queued while arrivals closed");
`endif

endmodule

### sim/dispatch_checker.sv
// Checker for the three-class priority queue dispatcher: watches the config, input and
// output channels, predicts each result from its own model of the queues and compares.
// Depends on tcpqd_pkg.
module dispatch_checker
    import tcpqd_pkg::*;
#(
    parameter int TOTAL_SLOTS = 20,
    parameter int PAUSE_LIMIT = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic              o_cfg_ready,
    input  logic              i_cfg_data,
    input  logic              i_in_valid,
    input  logic              o_in_stall,
    input  logic              i_mode,
    input  logic [CLS_W-1:0]  i_arrival_class,
    input  logic [TAG_W-1:0]  i_customer_tag,
    input  logic [TIME_W-1:0] i_service_time,
    input  logic [SRV_W-1:0]  i_server_index,
    input  logic              o_out_valid,
    input  logic              i_out_stall,
    input  logic [STAT_W-1:0] o_arrival_status,
    input  logic              o_grant_valid,
    input  logic [CLS_W-1:0]  o_granted_class,
    input  logic [TAG_W-1:0]  o_granted_tag,
    input  logic [TIME_W-1:0] o_granted_time,
    input  logic [OCC_W-1:0]  o_occupancy,
    input  logic              o_closed_flag,
    output int                fail_count,
    output int                outstanding,
    output int                pause_run,
    output int                predicted_occupancy,
    output bit                predicted_closed,
    output int                results_checked,
    output int                grants_seen,
    output int                drops_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [TAG_W-1:0]  tag_store  [NUM_CLASSES][TOTAL_SLOTS];
    logic [TIME_W-1:0] time_store [NUM_CLASSES][TOTAL_SLOTS];
    int                head_ptr   [NUM_CLASSES];
    int                fill       [NUM_CLASSES];
    bit                prefer_own_class;
    t_result           awaited_outcomes [$];

    function automatic int queued_total();
        return fill[0] + fill[1] + fill[2];
    endfunction

    function automatic bit pop_waiting(input int q, inout t_result r);
        int h;
        if (fill[q] == 0) return 1'b0;
        h = head_ptr[q];
        r.grant    = 1'b1;
        r.cls      = CLS_W'(q + 1);
        r.tag      = tag_store[q][h];
        r.svc_time = time_store[q][h];
        head_ptr[q] = (h + 1) % TOTAL_SLOTS;
        fill[q]--;
        return 1'b1;
    endfunction

    task automatic dispatch_outcome(
        input  logic              mode,
        input  logic [CLS_W-1:0]  cls,
        input  logic [TAG_W-1:0]  tag,
        input  logic [TIME_W-1:0] tim,
        input  logic [SRV_W-1:0]  srv,
        output t_result           r
    );
        int q;
        int slot;
        bit done;
        r = '0;
        r.stat = ARR_NONE;
        if (mode == MODE_ARRIVE) begin
            if (predicted_closed) begin
                r.stat = ARR_CLOSED;
            end else if (queued_total() >= TOTAL_SLOTS) begin
                r.stat = ARR_DROPPED;
            end else if (cls == CLS_PAUSE) begin
                pause_run++;
                if (pause_run >= PAUSE_LIMIT) begin
                    predicted_closed = 1'b1;
                    r.stat = ARR_CLOSED;
                end else begin
                    r.stat = ARR_PAUSE;
                end
            end else begin
                q = int'(cls) - 1;
                slot = (head_ptr[q] + fill[q]) % TOTAL_SLOTS;
                tag_store[q][slot]  = tag;
                time_store[q][slot] = tim;
                fill[q]++;
                pause_run = 0;
                r.stat = ARR_QUEUED;
            end
        end else begin
            done = 1'b0;
            if (prefer_own_class && srv < NUM_CLASSES) done = pop_waiting(int'(srv), r);
            if (!done && !pop_waiting(0, r) && !pop_waiting(1, r)) done = pop_waiting(2, r);
        end
        r.occ    = OCC_W'(queued_total());
        r.closed = predicted_closed;
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            for (int q = 0; q < NUM_CLASSES; q++) begin
                head_ptr[q] = 0;
                fill[q] = 0;
            end
            prefer_own_class = 1'b0;
            pause_run = 0;
            predicted_closed = 1'b0;
            awaited_outcomes.delete();
            fail_count = 0;
            results_checked = 0;
            grants_seen = 0;
            drops_seen = 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) prefer_own_class = i_cfg_data;
            if (i_in_valid && !o_in_stall) begin
                dispatch_outcome(i_mode, i_arrival_class, i_customer_tag, i_service_time,
                                 i_server_index, want);
                if (want.stat == ARR_DROPPED) drops_seen++;
                awaited_outcomes.insert(awaited_outcomes.size(), want);
            end
            if (o_out_valid && !i_out_stall) begin
                got.stat     = t_arr_status'(o_arrival_status);
                got.grant    = o_grant_valid;
                got.cls      = o_granted_class;
                got.tag      = o_granted_tag;
                got.svc_time = o_granted_time;
                got.occ      = o_occupancy;
                got.closed   = o_closed_flag;
                if (awaited_outcomes.size() == 0) begin
                    report_mismatch("result transfer with nothing awaited");
                end else begin
                    want = awaited_outcomes.pop_front();
                    results_checked++;
                    if (want.grant) grants_seen++;
                    check_field("arrival_status", 32'(got.stat), 32'(want.stat));
                    check_field("grant_valid", 32'(got.grant), 32'(want.grant));
                    check_field("granted_class", 32'(got.cls), 32'(want.cls));
                    check_field("granted_tag", 32'(got.tag), 32'(want.tag));
                    check_field("granted_time", 32'(got.svc_time), 32'(want.svc_time));
                    check_field("occupancy", 32'(got.occ), 32'(want.occ));
                    check_field("closed_flag", 32'(got.closed), 32'(want.closed));
                end
            end
        end
        outstanding = awaited_outcomes.size();
        predicted_occupancy = queued_total();
    end

endmodule

### sim/testbench.sv
// Top of the dispatcher testbench: clock, reset, stimulus with random idling on both
// channels, policy writes between phases, and the final verdict.
// Depends on tcpqd_pkg, three_class_priority_queue_dispatch and dispatch_checker.
module testbench;
    import tcpqd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   TOTAL_SLOTS      = 20;
    localparam int   PAUSE_LIMIT      = 3;
    localparam int   PHASE_ITEMS      = 310;
    localparam int   CYCLE_LIMIT      = 600000;
    localparam logic POLICY_FIXED     = 1'b0;
    localparam logic POLICY_PREFERRED = 1'b1;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic              i_cfg_data;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_mode;
    logic [CLS_W-1:0]  i_arrival_class;
    logic [TAG_W-1:0]  i_customer_tag;
    logic [TIME_W-1:0] i_service_time;
    logic [SRV_W-1:0]  i_server_index;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [STAT_W-1:0] o_arrival_status;
    logic              o_grant_valid;
    logic [CLS_W-1:0]  o_granted_class;
    logic [TAG_W-1:0]  o_granted_tag;
    logic [TIME_W-1:0] o_granted_time;
    logic [OCC_W-1:0]  o_occupancy;
    logic              o_closed_flag;

    int fail_count;
    int outstanding;
    int pause_run;
    int predicted_occupancy;
    bit predicted_closed;
    int results_checked;
    int grants_seen;
    int drops_seen;
    int items_sent = 0;
    int cycle_count = 0;
    int stall_left = 0;

    always #1 i_clk = ~i_clk;

    three_class_priority_queue_dispatch #(
        .TOTAL_SLOTS(TOTAL_SLOTS),
        .PAUSE_LIMIT(PAUSE_LIMIT)
    ) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_mode(i_mode),
        .i_arrival_class(i_arrival_class), .i_customer_tag(i_customer_tag),
        .i_service_time(i_service_time), .i_server_index(i_server_index),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_arrival_status(o_arrival_status), .o_grant_valid(o_grant_valid),
        .o_granted_class(o_granted_class), .o_granted_tag(o_granted_tag),
        .o_granted_time(o_granted_time), .o_occupancy(o_occupancy),
        .o_closed_flag(o_closed_flag)
    );

    dispatch_checker #(
        .TOTAL_SLOTS(TOTAL_SLOTS),
        .PAUSE_LIMIT(PAUSE_LIMIT)
    ) dispatch_watch (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_mode(i_mode),
        .i_arrival_class(i_arrival_class), .i_customer_tag(i_customer_tag),
        .i_service_time(i_service_time), .i_server_index(i_server_index),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_arrival_status(o_arrival_status), .o_grant_valid(o_grant_valid),
        .o_granted_class(o_granted_class), .o_granted_tag(o_granted_tag),
        .o_granted_time(o_granted_time), .o_occupancy(o_occupancy),
        .o_closed_flag(o_closed_flag),
        .fail_count(fail_count), .outstanding(outstanding), .pause_run(pause_run),
        .predicted_occupancy(predicted_occupancy), .predicted_closed(predicted_closed),
        .results_checked(results_checked), .grants_seen(grants_seen),
        .drops_seen(drops_seen)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still awaited", cycle_count,
                     outstanding);
            $display("Regression FAIL");
            $finish;
        end
    end

    // hold the result channel for random stretches, mostly short
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
        end else if (i_out_stall) begin
            i_out_stall <= 1'b0;
            stall_left = ($urandom_range(99) < 15) ? $urandom_range(20, 60) : $urandom_range(0, 6);
        end else if ($urandom_range(99) < 35) begin
            i_out_stall <= 1'b1;
            stall_left = ($urandom_range(99) < 10) ? $urandom_range(10, 40) : $urandom_range(0, 3);
        end
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic idle_gap(input int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    task automatic send_item(
        input logic              mode,
        input logic [CLS_W-1:0]  cls,
        input logic [TAG_W-1:0]  tag,
        input logic [TIME_W-1:0] tim,
        input logic [SRV_W-1:0]  srv
    );
        i_in_valid      <= 1'b1;
        i_mode          <= mode;
        i_arrival_class <= cls;
        i_customer_tag  <= tag;
        i_service_time  <= tim;
        i_server_index  <= srv;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_random(input int arrive_pct);
        logic             mode;
        logic [CLS_W-1:0] cls;
        mode = ($urandom_range(99) < arrive_pct) ? MODE_ARRIVE : MODE_SERVE;
        cls  = CLS_W'($urandom_range(3));
        // keep arrivals open: never let a counted pause reach the limit
        if (mode == MODE_ARRIVE && cls == CLS_PAUSE && predicted_occupancy < TOTAL_SLOTS
            && (pause_run >= PAUSE_LIMIT - 1 || $urandom_range(99) < 40))
            cls = CLS_W'($urandom_range(1, 3));
        send_item(mode, cls, TAG_W'($urandom_range(16'hFFFF)), TIME_W'($urandom_range(8'hFF)),
                  SRV_W'($urandom_range(3)));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_policy(input logic value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_random_phase(input int count);
        int arrive_pct;
        bit calm;
        arrive_pct = 50;
        calm = 1'b0;
        for (int n = 0; n < count; n++) begin
            if (n % 31 == 0) begin
                case ($urandom_range(3))
                    0: arrive_pct = 25;
                    1: arrive_pct = 50;
                    2: arrive_pct = 75;
                    default: arrive_pct = 92;
                endcase
                calm = ($urandom_range(99) < 20);
            end
            idle_gap(calm ? 0 : gap_length());
            send_random(arrive_pct);
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = 1'b0;
        i_in_valid      = 1'b0;
        i_mode          = MODE_ARRIVE;
        i_arrival_class = CLS_PAUSE;
        i_customer_tag  = '0;
        i_service_time  = '0;
        i_server_index  = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        write_policy(POLICY_FIXED);
        send_item(MODE_SERVE,  CLS_PAUSE, 16'h0000, 8'h00, 2'd0);
        send_item(MODE_ARRIVE, CLS_LOW,   16'hFFFF, 8'hFF, 2'd0);
        send_item(MODE_ARRIVE, CLS_MID,   16'h0000, 8'h00, 2'd1);
        send_item(MODE_ARRIVE, CLS_HIGH,  16'hA5A5, 8'h5A, 2'd2);
        send_item(MODE_ARRIVE, CLS_PAUSE, 16'h1234, 8'h12, 2'd3);
        send_item(MODE_ARRIVE, CLS_PAUSE, 16'h4321, 8'h21, 2'd0);
        send_item(MODE_ARRIVE, CLS_MID,   16'h5A5A, 8'hA5, 2'd1);
        send_item(MODE_ARRIVE, CLS_PAUSE, 16'h0F0F, 8'h0F, 2'd2);
        send_item(MODE_SERVE,  CLS_LOW,   16'hFFFF, 8'hFF, 2'd2);
        send_item(MODE_SERVE,  CLS_HIGH,  16'h0000, 8'h00, 2'd3);
        write_policy(POLICY_PREFERRED);
        send_item(MODE_SERVE,  CLS_PAUSE, 16'h0000, 8'h00, 2'd2);
        send_item(MODE_SERVE,  CLS_PAUSE, 16'h0000, 8'h00, 2'd0);
        send_item(MODE_SERVE,  CLS_PAUSE, 16'h0000, 8'h00, 2'd3);
        send_item(MODE_ARRIVE, CLS_HIGH,  16'h0001, 8'h01, 2'd0);
        send_item(MODE_ARRIVE, CLS_LOW,   16'h8000, 8'h80, 2'd0);
        send_item(MODE_SERVE,  CLS_PAUSE, 16'h0000, 8'h00, 2'd1);
        send_item(MODE_SERVE,  CLS_PAUSE, 16'h0000, 8'h00, 2'd1);
        send_item(MODE_ARRIVE, CLS_MID,   16'hFFFE, 8'h7F, 2'd3);
        send_item(MODE_ARRIVE, CLS_HIGH,  16'h7FFF, 8'hFE, 2'd3);
        send_item(MODE_SERVE,  CLS_PAUSE, 16'h0000, 8'h00, 2'd3);
        send_item(MODE_SERVE,  CLS_PAUSE, 16'h0000, 8'h00, 2'd1);
        send_item(MODE_SERVE,  CLS_PAUSE, 16'h0000, 8'h00, 2'd2);

        run_random_phase(PHASE_ITEMS);
        write_policy(POLICY_FIXED);
        run_random_phase(PHASE_ITEMS);
        write_policy(POLICY_PREFERRED);
        run_random_phase(PHASE_ITEMS);
        write_policy(POLICY_FIXED);
        run_random_phase(PHASE_ITEMS);

        // close arrivals with a run of pauses, draining first if full
        while (!predicted_closed) begin
            if (predicted_occupancy >= TOTAL_SLOTS)
                send_item(MODE_SERVE, CLS_PAUSE, 16'h0000, 8'h00, SRV_W'($urandom_range(3)));
            else
                send_item(MODE_ARRIVE, CLS_PAUSE, 16'h0000, 8'h00, 2'd0);
        end
        send_item(MODE_ARRIVE, CLS_HIGH,  16'hBEEF, 8'h33, 2'd0);
        send_item(MODE_ARRIVE, CLS_PAUSE, 16'h0000, 8'h00, 2'd0);
        for (int s = 0; s < 4; s++)
            send_item(MODE_SERVE, CLS_PAUSE, 16'h0000, 8'h00, SRV_W'(s));

        wait_drained();
        repeat (10) @(negedge i_clk);
        $display("Covered %0d input transfers and %0d checked results (%0d grants, %0d drops)",
                 items_sent, results_checked, grants_seen, drops_seen);
        $display("Both service policies ran; arrivals closed by a pause run at the end");
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### sim.f
rtl/tcpqd_pkg.sv
rtl/tcpqd_ram.sv
rtl/tcpqd_front.sv
rtl/tcpqd_back.sv
rtl/three_class_priority_queue_dispatch.sv
sim/dispatch_checker.sv
sim/testbench.sv
